FILE: rtl/core/mesi_snooping_cache_controller_macros.svh
// Assertion macros shared by the cache controller checker.
// Depends on nothing; included by the checker file only.
`ifndef MESI_SNOOPING_CACHE_CONTROLLER_MACROS_SVH
`define MESI_SNOOPING_CACHE_CONTROLLER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define MSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: rtl/core/msc_pkg.sv
// Package of the MESI cache controller: geometry, codes, beat layouts and state types.
// Depends on nothing.
`timescale 1ns / 1ps
package msc_pkg;
   localparam int NUM_LINES  = 64;
   localparam int ADDR_BITS  = 32;
   localparam int WORD_BITS  = 32;
   localparam int LINE_BITS  = 2 * WORD_BITS;
   localparam int IDX_BITS   = $clog2(NUM_LINES);
   localparam int LA_BITS    = ADDR_BITS - 1;
   localparam int TAG_BITS   = LA_BITS - IDX_BITS;
   localparam int META_BITS  = TAG_BITS + 2;

   typedef enum logic [1:0] {ST_I = 2'd0, ST_S = 2'd1, ST_E = 2'd2, ST_M = 2'd3} line_st_type;
   typedef enum logic [1:0] {OP_IDLE = 2'd0, OP_READ = 2'd1, OP_WRITE = 2'd2} pend_op_type;

   localparam logic [3:0] CMD_CPU_RD   = 4'd0;
   localparam logic [3:0] CMD_CPU_WR   = 4'd1;
   localparam logic [3:0] CMD_SNP_RD   = 4'd2;
   localparam logic [3:0] CMD_SNP_UPG  = 4'd3;
   localparam logic [3:0] CMD_SNP_RDX  = 4'd4;
   localparam logic [3:0] CMD_RD_REPLY = 4'd5;
   localparam logic [3:0] CMD_UPG_DONE = 4'd6;
   localparam logic [3:0] CMD_RDX_REP  = 4'd7;
   localparam logic [3:0] CMD_FLUSH_DN = 4'd8;

   localparam logic [2:0] KIND_RD_DONE = 3'd0;
   localparam logic [2:0] KIND_WR_DONE = 3'd1;
   localparam logic [2:0] KIND_BUS_REQ = 3'd2;
   localparam logic [2:0] KIND_SNOOP   = 3'd3;
   localparam logic [2:0] KIND_ERROR   = 3'd4;

   localparam logic [1:0] BUS_RD    = 2'd0;
   localparam logic [1:0] BUS_RDX   = 2'd1;
   localparam logic [1:0] BUS_UPGR  = 2'd2;
   localparam logic [1:0] BUS_FLUSH = 2'd3;

   typedef struct packed {
      logic [3:0]  req_cmd;
      logic [31:0] req_address;
      logic [31:0] req_write_data;
      logic [63:0] req_fill_line;
      logic        req_fill_dirty;
      logic        req_fill_shared;
   } req_beat_type;

   typedef struct packed {
      logic [2:0]  rsp_kind;
      logic [31:0] rsp_read_word;
      logic [1:0]  rsp_bus_request;
      logic [30:0] rsp_line_address;
      logic [63:0] rsp_line_out;
      logic        rsp_reply_dirty;
      logic        rsp_reply_shared;
   } rsp_beat_type;

   typedef enum logic [1:0] {FSM_IDLE, FSM_LOOKUP} fsm_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctl_type;

   typedef struct packed {
      logic out_full;
   } sts_type;
endpackage

FILE: rtl/core/msc_if.sv
// Valid/ready channel interface carrying one payload beat.
// Depends on nothing; the payload type is a parameter.
`timescale 1ns / 1ps
interface msc_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/mesi_snooping_cache_controller.sv
// Top level of the direct-mapped MESI snooping cache controller.
// Depends on msc_pkg, msc_if, msc_ctrl and msc_dpath.
// A request beat is taken in the idle state, which captures it and starts the registered
// read of the tag/state and line memories at its index. In the next cycle the controller
// decides the outcome, writes the line back and loads the response register, from which the
// response beat is offered. That step is held while the response register still holds a
// beat that is not being taken. Only one request is in flight; a new request beat is
// taken only once the current one has been executed and the idle state is back.
`timescale 1ns / 1ps
module mesi_snooping_cache_controller import msc_pkg::*; (
   input logic clock,
   input logic reset,
   msc_if.sink   req,
   msc_if.source rsp
);
   ctl_type ctl;
   sts_type sts;

   msc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(req.ready),
      .sts(sts), .ctl(ctl));

   msc_dpath u_dpath (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts),
      .cmd(req.data.req_cmd), .address(req.data.req_address),
      .write_data(req.data.req_write_data), .fill_line(req.data.req_fill_line),
      .fill_dirty(req.data.req_fill_dirty), .fill_shared(req.data.req_fill_shared),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .o_kind(rsp.data.rsp_kind), .o_read_word(rsp.data.rsp_read_word),
      .o_bus_request(rsp.data.rsp_bus_request),
      .o_line_address(rsp.data.rsp_line_address), .o_line_out(rsp.data.rsp_line_out),
      .o_reply_dirty(rsp.data.rsp_reply_dirty), .o_reply_shared(rsp.data.rsp_reply_shared));
endmodule

FILE: rtl/core/msc_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module msc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

FILE: rtl/core/msc_ctrl.sv
// Controller state machine: capture, then lookup and write back once the response
// register is free. Depends on msc_pkg.
`timescale 1ns / 1ps
module msc_ctrl import msc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  sts_type sts,
   output ctl_type ctl
);
   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE:   if (in_valid) state_in = FSM_LOOKUP;
         FSM_LOOKUP: if (!sts.out_full) state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      in_ready = 1'b0;
      ctl      = '0;
      unique case (state_ff)
         FSM_IDLE:   begin
            in_ready    = 1'b1;
            ctl.capture = in_valid;
         end
         FSM_LOOKUP: ctl.execute = !sts.out_full;
         default:    ctl = '0;
      endcase
   end
endmodule

FILE: rtl/core/msc_dpath.sv
// Datapath: line memories, pending miss registers, MESI decisions, output register.
// Depends on msc_pkg and msc_ram.
`timescale 1ns / 1ps
module msc_dpath import msc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl,
   output sts_type               sts,
   input  logic [3:0]            cmd,
   input  logic [31:0]           address,
   input  logic [31:0]           write_data,
   input  logic [63:0]           fill_line,
   input  logic                  fill_dirty,
   input  logic                  fill_shared,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [2:0]            o_kind,
   output logic [31:0]           o_read_word,
   output logic [1:0]            o_bus_request,
   output logic [30:0]           o_line_address,
   output logic [63:0]           o_line_out,
   output logic                  o_reply_dirty,
   output logic                  o_reply_shared
);
   logic [3:0]           cmd_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [WORD_BITS-1:0] wdata_ff;
   logic [LINE_BITS-1:0] fill_ff;
   logic                 fdirty_ff, fshared_ff;
   pend_op_type          pop_ff, pop_in;
   logic [ADDR_BITS-1:0] paddr_ff, paddr_in;
   logic [WORD_BITS-1:0] pword_ff, pword_in;
   logic [NUM_LINES-1:0] vld_ff;

   // A reply or flush-done command targets the pending address; others the item address.
   logic [ADDR_BITS-1:0] cap_addr, eff_addr;
   logic [LA_BITS-1:0]   la;
   logic [IDX_BITS-1:0]  idx, cap_idx;
   logic [TAG_BITS-1:0]  tag;

   logic [META_BITS-1:0] meta_rd, meta_wr;
   logic [LINE_BITS-1:0] data_rd, data_wr;
   logic                 meta_we, data_we;
   logic [TAG_BITS-1:0]  cur_tag;
   line_st_type          cur_st, new_st;
   logic [TAG_BITS-1:0]  new_tag;
   logic                 match;

   logic [2:0]           r_kind;
   logic [31:0]          r_rw;
   logic [1:0]           r_req;
   logic [30:0]          r_la;
   logic [63:0]          r_lo;
   logic                 r_d, r_s;
   logic                 full_ff;

   assign cap_addr = (cmd >= CMD_RD_REPLY && cmd <= CMD_FLUSH_DN) ? paddr_ff
                                                                   : address[ADDR_BITS-1:0];
   assign cap_idx  = cap_addr[IDX_BITS:1];
   assign eff_addr = (cmd_ff >= CMD_RD_REPLY && cmd_ff <= CMD_FLUSH_DN) ? paddr_ff : addr_ff;
   assign la       = eff_addr[ADDR_BITS-1:1];
   assign idx      = la[IDX_BITS-1:0];
   assign tag      = la[LA_BITS-1:IDX_BITS];

   assign cur_tag  = vld_ff[idx] ? meta_rd[META_BITS-1:2] : '0;
   assign cur_st   = vld_ff[idx] ? line_st_type'(meta_rd[1:0]) : ST_I;
   assign match    = cur_tag == tag;

   msc_ram #(.WIDTH(META_BITS), .DEPTH(NUM_LINES)) u_meta (
      .clock(clock), .wr_en(meta_we), .addr(ctl.capture ? cap_idx : idx),
      .wr_data(meta_wr), .rd_data(meta_rd));
   msc_ram #(.WIDTH(LINE_BITS), .DEPTH(NUM_LINES)) u_data (
      .clock(clock), .wr_en(data_we), .addr(ctl.capture ? cap_idx : idx),
      .wr_data(data_wr), .rd_data(data_rd));

   function automatic logic [LINE_BITS-1:0] put_word(input logic [LINE_BITS-1:0] line,
         input logic sel, input logic [WORD_BITS-1:0] w);
      logic [LINE_BITS-1:0] res;
      res = line;
      if (sel) res[LINE_BITS-1:WORD_BITS] = w;
      else res[WORD_BITS-1:0] = w;
      return res;
   endfunction

   always_comb begin
      logic ok;
      logic [LINE_BITS-1:0] line;
      r_kind = KIND_ERROR; r_rw = '0; r_req = BUS_RD; r_la = '0; r_lo = '0;
      r_d = 1'b0; r_s = 1'b0;
      new_tag = cur_tag; new_st = cur_st; meta_we = 1'b0; data_we = 1'b0;
      data_wr = data_rd; pop_in = pop_ff; paddr_in = paddr_ff; pword_in = pword_ff;
      ok = 1'b0; line = data_rd;
      case (cmd_ff)
         CMD_CPU_RD, CMD_CPU_WR: begin
            if (pop_ff == OP_IDLE) begin
               if (match && cur_st != ST_I && cmd_ff == CMD_CPU_RD) begin
                  r_kind = KIND_RD_DONE;
                  r_rw = 32'(addr_ff[0] ? data_rd[LINE_BITS-1:WORD_BITS]
                                        : data_rd[WORD_BITS-1:0]);
               end else if (match && (cur_st == ST_E || cur_st == ST_M)) begin
                  new_st = ST_M; meta_we = 1'b1; data_we = 1'b1;
                  data_wr = put_word(data_rd, addr_ff[0], wdata_ff);
                  r_kind = KIND_WR_DONE;
               end else begin
                  pop_in = (cmd_ff == CMD_CPU_RD) ? OP_READ : OP_WRITE;
                  paddr_in = addr_ff; pword_in = wdata_ff;
                  r_kind = KIND_BUS_REQ;
                  if (!match && cur_st == ST_M) begin
                     r_req = BUS_FLUSH; r_la = 31'({cur_tag, idx}); r_lo = 64'(data_rd);
                  end else begin
                     if (!match) begin
                        new_tag = tag; new_st = ST_I; meta_we = 1'b1;
                     end
                     r_req = (cmd_ff == CMD_CPU_RD) ? BUS_RD
                           : ((match && cur_st == ST_S) ? BUS_UPGR : BUS_RDX);
                     r_la = 31'(la);
                  end
               end
            end
         end
         CMD_SNP_RD, CMD_SNP_UPG, CMD_SNP_RDX: begin
            r_kind = KIND_SNOOP; r_la = 31'(la);
            if (match && cur_st != ST_I) begin
               meta_we = 1'b1;
               if (cmd_ff == CMD_SNP_UPG) begin
                  new_st = ST_I;
               end else begin
                  r_lo = 64'(data_rd);
                  r_s = cur_st == ST_S; r_d = cur_st != ST_S;
                  new_st = (cmd_ff == CMD_SNP_RD) ? ST_S : ST_I;
               end
            end
         end
         CMD_RD_REPLY, CMD_UPG_DONE, CMD_RDX_REP, CMD_FLUSH_DN: begin
            case (cmd_ff)
               CMD_FLUSH_DN: ok = pop_ff != OP_IDLE && !match;
               CMD_RD_REPLY: ok = pop_ff == OP_READ && match && cur_st == ST_I;
               CMD_UPG_DONE: ok = pop_ff == OP_WRITE && match && cur_st == ST_S;
               default:      ok = pop_ff == OP_WRITE && match && cur_st == ST_I;
            endcase
            if (ok) begin
               if (cmd_ff == CMD_FLUSH_DN) begin
                  new_tag = tag; new_st = ST_I; meta_we = 1'b1;
                  r_kind = KIND_BUS_REQ; r_la = 31'(la);
                  r_req = (pop_ff == OP_READ) ? BUS_RD : BUS_RDX;
               end else if (cmd_ff == CMD_RD_REPLY) begin
                  data_we = 1'b1; data_wr = fill_ff; meta_we = 1'b1;
                  new_st = (!fdirty_ff && !fshared_ff) ? ST_E : ST_S;
                  r_kind = KIND_RD_DONE;
                  r_rw = 32'(paddr_ff[0] ? fill_ff[LINE_BITS-1:WORD_BITS]
                                         : fill_ff[WORD_BITS-1:0]);
                  pop_in = OP_IDLE;
               end else begin
                  if (cmd_ff == CMD_RDX_REP) line = fill_ff;
                  data_we = 1'b1; data_wr = put_word(line, paddr_ff[0], pword_ff);
                  meta_we = 1'b1; new_st = ST_M; r_kind = KIND_WR_DONE;
                  pop_in = OP_IDLE;
               end
            end
         end
         default: r_kind = KIND_ERROR;
      endcase
      meta_we = meta_we && ctl.execute;
      data_we = data_we && ctl.execute;
      meta_wr = {new_tag, new_st};
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff <= cmd; addr_ff <= address[ADDR_BITS-1:0];
         wdata_ff <= write_data[WORD_BITS-1:0]; fill_ff <= fill_line[LINE_BITS-1:0];
         fdirty_ff <= fill_dirty; fshared_ff <= fill_shared;
      end
      if (ctl.execute) begin
         o_kind <= r_kind; o_read_word <= r_rw; o_bus_request <= r_req;
         o_line_address <= r_la; o_line_out <= r_lo;
         o_reply_dirty <= r_d; o_reply_shared <= r_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_ff <= OP_IDLE; paddr_ff <= '0; pword_ff <= '0; vld_ff <= '0; full_ff <= 1'b0;
      end else begin
         if (ctl.execute) begin
            pop_ff <= pop_in; paddr_ff <= paddr_in; pword_ff <= pword_in;
            if (meta_we) vld_ff[idx] <= 1'b1;
         end
         if (ctl.execute) begin
            full_ff <= 1'b1;
         end else if (out_valid && out_ready) begin
            full_ff <= 1'b0;
         end
      end
   end

   assign sts.out_full = full_ff && !out_ready;
   assign out_valid    = full_ff;
endmodule

FILE: rtl/core/msc_checker.sv
// Port-level checker for the MESI cache controller, bound to the top level.
// Depends on msc_pkg, msc_if and the assertion macro header.
`timescale 1ns / 1ps
`include "mesi_snooping_cache_controller_macros.svh"
module msc_checker import msc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [1:0] rsp_bus_request,
   input logic       rsp_reply_dirty,
   input logic       rsp_reply_shared
);
   `MSC_ASSERT_IMP(a_kind_range, clock, reset, rsp_valid, rsp_kind <= KIND_ERROR)
   `MSC_ASSERT_IMP(a_flags_excl, clock, reset, rsp_valid, !(rsp_reply_dirty && rsp_reply_shared))
   `MSC_ASSERT_NEXT(a_one_busy, clock, reset, req_valid && req_ready, !req_ready)
   `MSC_ASSERT_IMP(a_req_only_bus, clock, reset, rsp_valid && rsp_kind != KIND_BUS_REQ,
      rsp_bus_request == BUS_RD)
endmodule

bind mesi_snooping_cache_controller msc_checker u_msc_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_kind(rsp.data.rsp_kind),
   .rsp_bus_request(rsp.data.rsp_bus_request),
   .rsp_reply_dirty(rsp.data.rsp_reply_dirty),
   .rsp_reply_shared(rsp.data.rsp_reply_shared));
